FILE: hdl/hmo_pkg.sv
// Shared types and constants for the mirrored strided offset calculator.
// No dependencies; every other file in hdl/ imports this package.
package hmo_pkg;

    localparam int IdxW    = 32;
    localparam int OffW    = 48;
    localparam int NumGeom = 6;
    // Division steps plus mirror, multiply and accumulate stages per dimension.
    localparam int DimLat  = IdxW + 3;

    typedef enum logic [2:0] {
        REG_DIM0   = 3'd0,
        REG_DIM1   = 3'd1,
        REG_DIM2   = 3'd2,
        REG_DIM3   = 3'd3,
        REG_DIM4   = 3'd4,
        REG_DIM5   = 3'd5,
        REG_ACTIVE = 3'd6,
        REG_MIRROR = 3'd7
    } reg_idx_t;

    // Item travelling down the chain: partial remainder, the shifting
    // dividend/quotient word and the running offset sum.
    typedef struct packed {
        logic            valid;
        logic [IdxW-1:0] rem;
        logic [IdxW-1:0] quo;
        logic [OffW-1:0] acc;
    } hmo_flow_t;

endpackage

FILE: hdl/hermitian_mirror_offset_calc.sv
// Top level of the mirrored strided offset calculator: register file and dimension chain.
// Depends on hmo_pkg and hmo_dim.
//
// Takes one index every cycle (busy is never raised) and returns its offset
// through each dimension in turn: 32 cells of a bit-serial divider, then
// mirror, multiply and accumulate. The result is shown with done for one cycle
// and cannot be held off, so the receiver must take every transfer. Dimensions
// beyond the active count divide by one and add nothing, so latency does not
// depend on configuration. Registers may only be written while no item is in
// flight.
module hermitian_mirror_offset_calc #(
    parameter int MAX_DIMS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [5:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [hmo_pkg::IdxW-1:0]        linear_index,
    output logic                            done,
    output logic signed [hmo_pkg::OffW-1:0] element_offset
);
    import hmo_pkg::*;

    localparam logic [2:0] MaxDimsW = 3'(MAX_DIMS);

    logic [63:0] geom_reg [NumGeom];
    logic [2:0]  active_reg;
    logic [5:0]  mirror_reg;
    logic [2:0]  used;
    reg_idx_t    widx;
    logic        wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NumGeom; k++)
            begin
                geom_reg[k] <= 64'd1;
            end
            active_reg <= '0;
            mirror_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_ACTIVE: active_reg <= pwdata[2:0];
                REG_MIRROR: mirror_reg <= pwdata[5:0];
                default:    geom_reg[paddr[5:3]] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_ACTIVE: prdata = {61'd0, active_reg};
            REG_MIRROR: prdata = {58'd0, mirror_reg};
            default:    prdata = geom_reg[paddr[5:3]];
        endcase
    end

    assign used = (active_reg > MaxDimsW) ? MaxDimsW : active_reg;

    hmo_flow_t link [MAX_DIMS+1];

    always_comb
    begin
        link[0].valid = start && !busy;
        link[0].rem   = '0;
        link[0].quo   = linear_index;
        link[0].acc   = '0;
    end

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_dim
        logic [IdxW-1:0] divisor;

        // Size zero and inactive dimensions divide by one: digit zero, quotient passes.
        assign divisor = (3'(d) < used && geom_reg[d][31:0] != '0) ? geom_reg[d][31:0]
                                                                   : IdxW'(1);

        hmo_dim u_dim (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (divisor),
            .stride    ($signed(geom_reg[d][63:32])),
            .mirror_en (mirror_reg[d]),
            .flow_in   (link[d]),
            .flow_out  (link[d+1])
        );
    end

    assign done           = link[MAX_DIMS].valid;
    assign element_offset = $signed(link[MAX_DIMS].acc);

endmodule

FILE: hdl/hmo_div_cell.sv
// One restoring-division step: brings in one dividend bit, yields one quotient bit.
// Depends on hmo_pkg.
module hmo_div_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [hmo_pkg::IdxW-1:0] divisor,
    input  hmo_pkg::hmo_flow_t      flow_in,
    output hmo_pkg::hmo_flow_t      flow_out
);
    import hmo_pkg::*;

    hmo_flow_t     flow_reg;
    hmo_flow_t     flow_next;
    logic [IdxW:0] trial;
    logic          fits;

    always_comb
    begin
        trial     = {flow_in.rem, flow_in.quo[IdxW-1]};
        fits      = trial >= {1'b0, divisor};
        flow_next = flow_in;
        flow_next.rem = fits ? IdxW'(trial - {1'b0, divisor}) : trial[IdxW-1:0];
        flow_next.quo = {flow_in.quo[IdxW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg <= '0;
        end
        else
        begin
            flow_reg <= flow_next;
        end
    end

    assign flow_out = flow_reg;

endmodule

FILE: hdl/hmo_dim.sv
// One dimension: a chain of division cells, then mirror, multiply and accumulate.
// Depends on hmo_pkg and hmo_div_cell.
module hmo_dim (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [hmo_pkg::IdxW-1:0] divisor,
    input  logic signed [31:0]       stride,
    input  logic                     mirror_en,
    input  hmo_pkg::hmo_flow_t       flow_in,
    output hmo_pkg::hmo_flow_t       flow_out
);
    import hmo_pkg::*;

    hmo_flow_t chain [IdxW+1];

    assign chain[0] = flow_in;

    for (genvar j = 0; j < IdxW; j++)
    begin : g_cell
        hmo_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (divisor),
            .flow_in  (chain[j]),
            .flow_out (chain[j+1])
        );
    end

    logic            mir_valid_reg, mul_valid_reg, acc_valid_reg;
    logic [IdxW-1:0] mir_digit_reg, mir_digit_next;
    logic [IdxW-1:0] mir_quo_reg, mul_quo_reg, acc_quo_reg;
    logic [OffW-1:0] mir_acc_reg, mul_acc_reg, acc_sum_reg;
    logic [OffW-1:0] mul_prod_reg;
    logic signed [64:0] prod_full;

    // After the last cell, rem holds the digit and quo the quotient.
    always_comb
    begin
        if (mirror_en && chain[IdxW].rem != '0)
        begin
            mir_digit_next = divisor - chain[IdxW].rem;
        end
        else
        begin
            mir_digit_next = chain[IdxW].rem;
        end
    end

    assign prod_full = $signed({1'b0, mir_digit_reg}) * stride;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mir_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            mir_valid_reg <= chain[IdxW].valid;
            mul_valid_reg <= mir_valid_reg;
            acc_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mir_digit_reg <= mir_digit_next;
        mir_quo_reg   <= chain[IdxW].quo;
        mir_acc_reg   <= chain[IdxW].acc;
        mul_prod_reg  <= prod_full[OffW-1:0];
        mul_quo_reg   <= mir_quo_reg;
        mul_acc_reg   <= mir_acc_reg;
        acc_sum_reg   <= mul_acc_reg + mul_prod_reg;
        acc_quo_reg   <= mul_quo_reg;
    end

    always_comb
    begin
        flow_out.valid = acc_valid_reg;
        flow_out.rem   = '0;
        flow_out.quo   = acc_quo_reg;
        flow_out.acc   = acc_sum_reg;
    end

endmodule

FILE: hdl/hmo_checker.sv
// Port-level checks for the offset calculator, bound to the top level.
// Depends on hmo_pkg.
module hmo_checker #(
    parameter int MAX_DIMS = 6
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);
    import hmo_pkg::*;

    localparam int Lat = DimLat * MAX_DIMS;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // Every accepted transfer comes out after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Lat done)
        else $error("result missing");

    // No result appears without a transfer accepted at the matching time.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Lat))
        else $error("unexpected result");

endmodule

bind hermitian_mirror_offset_calc hmo_checker #(.MAX_DIMS(MAX_DIMS)) u_hmo_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);

FILE: test/hermitian_mirror_offset_calc_tb.sv
// Testbench for the mirrored strided offset calculator: APB register setup,
// directed and random index streams, offsets checked against an in-bench predictor.
// Depends on hmo_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module hermitian_mirror_offset_calc_tb;
    import hmo_pkg::*;

    localparam int Latency  = DimLat * 6;
    localparam int WatchLim = 4 * Latency + 2000;
    localparam int NumDir   = 16;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [5:0]             paddr;
    logic [63:0]            pwdata;
    logic [63:0]            prdata;
    logic                   pready;
    logic                   start;
    logic                   busy;
    logic [IdxW-1:0]        linear_index;
    logic                   done;
    logic signed [OffW-1:0] element_offset;

    hermitian_mirror_offset_calc i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .linear_index   (linear_index),
        .done           (done),
        .element_offset (element_offset)
    );

    // Local copy of the register file used for prediction.
    logic [63:0]     geom [NumGeom];
    logic [2:0]      active_cnt;
    logic [5:0]      mirror_bits;

    logic [OffW-1:0] offset_queue [$];
    int              mismatches;
    int              idle_cycles;
    int              sender_idle_pct;
    bit              timed_out;

    typedef struct {
        logic [IdxW-1:0] idx;
        bit              known;
        logic [OffW-1:0] offset;
    } dir_row_t;

    dir_row_t dir_rows [NumDir];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [OffW-1:0] predict_offset(input logic [IdxW-1:0] idx);
        logic [63:0] rest;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] digit;
        logic [63:0] stride;
        int          used;
        rest = {32'd0, idx};
        sum  = '0;
        used = (active_cnt > 6) ? 6 : active_cnt;
        for (int k = 0; k < used; k++)
        begin
            n = {32'd0, geom[k][31:0]};
            if (n == 0)
                n = 1;
            digit = rest % n;
            rest  = rest / n;
            if (mirror_bits[k] && digit != 0)
                digit = n - digit;
            stride = {{32{geom[k][63]}}, geom[k][63:32]};
            sum    = sum + digit * stride;
        end
        return sum[OffW-1:0];
    endfunction

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NumGeom)
            geom[idx] = value;
        else if (idx == REG_ACTIVE)
            active_cnt = value[2:0];
        else
            mirror_bits = value[5:0];
    endtask

    // Waits until every outstanding offset has come back, then for the pipeline.
    task automatic drain();
        start <= 1'b0;
        while (offset_queue.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    // Drives one index transfer; the expected offset is queued at the accepting edge.
    // start stays high after the transfer so that the next one can follow at once.
    task automatic send_index(input logic [IdxW-1:0] idx, input bit known,
                              input logic [OffW-1:0] offset);
        logic [OffW-1:0] expected;
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        linear_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected     = known ? offset : predict_offset(idx);
        offset_queue = {offset_queue, expected};
        @(negedge clk);
    endtask

    task automatic random_geometry();
        logic [31:0] size;
        for (int k = 0; k < NumGeom; k++)
        begin
            case ($urandom_range(5, 0))
                0: size = 0;
                1: size = 32'hFFFF_FFFF;
                2: size = $urandom;
                default: size = $urandom_range(17, 1);
            endcase
            reg_write(reg_idx_t'(k), {$urandom, size});
        end
        reg_write(REG_ACTIVE, {61'd0, 3'($urandom_range(7, 0))});
        reg_write(REG_MIRROR, {58'd0, 6'($urandom)});
    endtask

    function automatic logic [IdxW-1:0] random_index();
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return $urandom_range(1023, 0);
            2: return ~($urandom_range(15, 0));
            default: return $urandom_range(200000, 0);
        endcase
    endfunction

    // Checks each offset in the cycle its done strobe is high.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (offset_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected offset %h", element_offset);
            end
            else if (offset_queue[0] !== element_offset)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("offset mismatch: expected %h, got %h",
                             offset_queue[0], element_offset);
                void'(offset_queue.pop_front());
            end
            else
                void'(offset_queue.pop_front());
        end
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLim && !timed_out)
        begin
            timed_out = 1'b1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        linear_index    = '0;
        rst_n           = 1'b0;
        mismatches      = 0;
        idle_cycles     = 0;
        timed_out       = 1'b0;
        sender_idle_pct = 0;
        for (int k = 0; k < NumGeom; k++)
            geom[k] = 64'd1;
        active_cnt  = '0;
        mirror_bits = '0;

        // Rows 0-1 run with reset registers: no active dimension, offset zero.
        dir_rows[0] = '{32'd0, 1'b1, 48'd0};
        dir_rows[1] = '{32'hFFFF_FFFF, 1'b1, 48'd0};
        dir_rows[2] = '{32'd0, 1'b1, 48'd0};
        dir_rows[3] = '{32'hFFFF_FFFF, 1'b0, 48'd0};
        dir_rows[4] = '{32'd1, 1'b0, 48'd0};
        dir_rows[5] = '{32'd7, 1'b0, 48'd0};
        dir_rows[6] = '{32'h8000_0000, 1'b0, 48'd0};
        dir_rows[7] = '{32'h5555_5555, 1'b0, 48'd0};
        dir_rows[8] = '{32'hAAAA_AAAA, 1'b0, 48'd0};
        for (int r = 9; r < NumDir; r++)
            dir_rows[r] = '{32'(r * 37 + 5), 1'b0, 48'd0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 16;
        for (int r = 0; r < 2; r++)
            send_index(dir_rows[r].idx, dir_rows[r].known, dir_rows[r].offset);
        drain();

        // Extreme geometry: a full size, most negative and positive strides,
        // one zero size, all mirrored, active count above the maximum.
        reg_write(REG_DIM0, {32'h8000_0000, 32'd3});
        reg_write(REG_DIM1, {32'h7FFF_FFFF, 32'd0});
        reg_write(REG_DIM2, {32'hFFFF_FFFF, 32'd5});
        reg_write(REG_DIM3, {32'h0000_0001, 32'hFFFF_FFFF});
        reg_write(REG_DIM4, {32'h8000_0000, 32'd2});
        reg_write(REG_DIM5, {32'h7FFF_FFFF, 32'd7});
        reg_write(REG_ACTIVE, 64'd7);
        reg_write(REG_MIRROR, 64'h3F);
        for (int r = 2; r < NumDir; r++)
            send_index(dir_rows[r].idx, dir_rows[r].known, dir_rows[r].offset);
        drain();
        reg_write(REG_MIRROR, 64'h0);
        reg_write(REG_ACTIVE, 64'd6);
        for (int r = 2; r < NumDir; r++)
            send_index(dir_rows[r].idx, 1'b0, 48'd0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 75 : 0;
            for (int set = 0; set < 10; set++)
            begin
                random_geometry();
                for (int i = 0; i < 54; i++)
                    send_index(random_index(), 1'b0, 48'd0);
                drain();
            end
        end

        if (mismatches == 0 && offset_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
